[rtl/core/ocap_pkg.sv]
// Shared types, constants and the sine table for the orbit camera block.
`default_nettype none

package ocap_pkg;

    // Field widths fixed by the interface
    localparam int POSITION_WIDTH_DEF = 24;
    localparam int STEP_W             = 6;
    localparam int LEN_W              = 16;
    localparam int YAW_W              = 9;
    localparam int PITCH_W            = 8;
    localparam int KEY_W              = 4;
    localparam int WORK_W             = 10;
    localparam int CFG_ADDR_W         = 3;
    localparam int CFG_DATA_W         = 16;

    // Trigonometry in Q2.14
    localparam int SINE_TABLE_ENTRIES = 91;
    localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_W             = 15;
    localparam int TRIG_W             = 16;
    localparam int CPR_W              = 32;
    localparam int PROD_W             = TRIG_W + CPR_W;

    // Angle constants in whole degrees
    localparam logic signed [WORK_W-1:0] DEG_HALF_TURN = 10'sd180;
    localparam logic signed [WORK_W-1:0] DEG_FULL_TURN = 10'sd360;
    localparam logic signed [YAW_W-1:0]  DEG_RIGHT     = 9'sd90;
    localparam logic [YAW_W-1:0]         DEG_MAX_ABS   = 9'd180;

    // Reset values of the registers and the angle state
    localparam logic [STEP_W-1:0]         RST_ANGLE_STEP = 6'd3;
    localparam logic [LEN_W-1:0]          RST_HEIGHT     = 16'd240;
    localparam logic [LEN_W-1:0]          RST_DISTANCE   = 16'd1600;
    localparam logic signed [PITCH_W-1:0] RST_PITCH_MIN  = -8'sd5;
    localparam logic signed [PITCH_W-1:0] RST_PITCH_MAX  = 8'sd89;
    localparam logic signed [YAW_W-1:0]   RST_YAW        = 9'sd0;
    localparam logic signed [PITCH_W-1:0] RST_PITCH      = -8'sd3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ANGLE_STEP     = 3'd0,
        CFG_LOOK_HEIGHT    = 3'd1,
        CFG_ORBIT_DISTANCE = 3'd2,
        CFG_PITCH_MIN      = 3'd3,
        CFG_PITCH_MAX      = 3'd4
    } t_cfg_reg;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_SP_R   = 2'd0,
        MUL_CP_R   = 2'd1,
        MUL_SY_CPR = 2'd2,
        MUL_CY_CPR = 2'd3
    } t_mul_sel;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic     load_in;
        logic     upd_angle;
        logic     trig_pitch;
        logic     trig_yaw;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     add_y;
        logic     add_x;
        logic     add_z;
        logic     out_load;
    } t_dp_cmd;

    // round(16384 * sin(d)) for d = 0..90 degrees
    localparam logic [SINE_W-1:0] SINE_Q14 [SINE_TABLE_ENTRIES] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11983, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    // Table read; indexes past the last entry cannot occur and read as zero.
    function automatic logic [SINE_W-1:0] f_sine(input logic [SINE_IDX_W-1:0] idx);
        logic [SINE_W-1:0] val;
        val = '0;
        if (idx < SINE_IDX_W'(SINE_TABLE_ENTRIES)) begin
            val = SINE_Q14[idx];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ocap_ctrl.sv]
// Sequencer that steps the orbit camera datapath through one word.
`default_nettype none

module ocap_ctrl
    import ocap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_ANGLE   = 10'b00_0000_0010,
        ST_TRIG_P  = 10'b00_0000_0100,
        ST_TRIG_Y  = 10'b00_0000_1000,
        ST_MUL_DY  = 10'b00_0001_0000,
        ST_MUL_CPR = 10'b00_0010_0000,
        ST_MUL_DX  = 10'b00_0100_0000,
        ST_MUL_DZ  = 10'b00_1000_0000,
        ST_ADD_DZ  = 10'b01_0000_0000,
        ST_OUT     = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // The output register may be refilled once it is empty or being taken.
    // No input word is taken while reset is held.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_SP_R;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                o_cmd.upd_angle = 1'b1;
                n_state = ST_TRIG_P;
            end
            ST_TRIG_P: begin
                o_cmd.trig_pitch = 1'b1;
                n_state = ST_TRIG_Y;
            end
            ST_TRIG_Y: begin
                o_cmd.trig_yaw = 1'b1;
                n_state = ST_MUL_DY;
            end
            ST_MUL_DY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SP_R;
                n_state = ST_MUL_CPR;
            end
            ST_MUL_CPR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CP_R;
                o_cmd.add_y   = 1'b1;
                n_state = ST_MUL_DX;
            end
            ST_MUL_DX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SY_CPR;
                n_state = ST_MUL_DZ;
            end
            ST_MUL_DZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CY_CPR;
                o_cmd.add_x   = 1'b1;
                n_state = ST_ADD_DZ;
            end
            ST_ADD_DZ: begin
                o_cmd.add_z = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ocap_dp.sv]
// Datapath of the orbit camera: registers, angle update, trig, multiplier, adder.
`default_nettype none

module ocap_dp
    import ocap_pkg::*;
#(
    parameter int  POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int IN_FIELD_W     = KEY_W + 3 * POSITION_WIDTH,
    localparam int IN_W           = ((IN_FIELD_W + 7) / 8) * 8,
    localparam int OUT_FIELD_W    = 6 * POSITION_WIDTH + YAW_W + PITCH_W,
    localparam int OUT_W          = ((OUT_FIELD_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [IN_W-1:0]       i_in_data,
    output logic [OUT_W-1:0]           o_out_data
);

    localparam int PW    = POSITION_WIDTH;
    localparam int SUM_W = PROD_W + 1;

    localparam logic signed [PROD_W-1:0] HALF_14 = PROD_W'(1) <<< 13;
    localparam logic signed [PROD_W-1:0] HALF_28 = PROD_W'(1) <<< 27;

    // Saturate a wide sum to the position width.
    function automatic logic signed [PW-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic in_range;
        logic signed [PW-1:0] res;
        in_range = (&v[SUM_W-1:PW-1]) || !(|v[SUM_W-1:PW-1]);
        if (in_range) begin
            res = v[PW-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(PW-1){1'b0}}};
        end else begin
            res = {1'b0, {(PW-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration and angle state
    logic [STEP_W-1:0]         r_step;
    logic [LEN_W-1:0]          r_height;
    logic [LEN_W-1:0]          r_dist;
    logic signed [PITCH_W-1:0] r_pmin, r_pmax;
    logic signed [YAW_W-1:0]   r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;

    // Working registers of the item in progress
    logic [KEY_W-1:0]          r_keys;
    logic signed [PW-1:0]      r_px, r_py, r_pz, r_ty;
    logic signed [PW-1:0]      r_cam_x, r_cam_y, r_cam_z;
    logic signed [TRIG_W-1:0]  r_sp, r_cp, r_sy, r_cy;
    logic signed [CPR_W-1:0]   r_cpr;
    logic signed [PROD_W-1:0]  r_prod;
    logic [OUT_W-1:0]          r_out_data;

    // Angle update
    logic signed [WORK_W-1:0]  w_step;
    logic signed [WORK_W-1:0]  w_y0, w_yd, w_y1, w_yu, w_y2;
    logic signed [WORK_W-1:0]  w_p0, w_pd, w_p1, w_pu, w_p2;
    logic signed [WORK_W-1:0]  w_pmin, w_pmax;
    logic signed [SUM_W-1:0]   w_ty_sum;

    always_comb begin
        w_step = $signed({{(WORK_W-STEP_W){1'b0}}, r_step});
        w_pmin = {{(WORK_W-PITCH_W){r_pmin[PITCH_W-1]}}, r_pmin};
        w_pmax = {{(WORK_W-PITCH_W){r_pmax[PITCH_W-1]}}, r_pmax};

        // Yaw: down first, then up, each wrapping by a full turn.
        w_y0 = {{(WORK_W-YAW_W){r_yaw[YAW_W-1]}}, r_yaw};
        w_yd = w_y0 - w_step;
        w_y1 = w_y0;
        if (r_keys[0]) begin
            w_y1 = (w_yd <= -DEG_HALF_TURN) ? (w_yd + DEG_FULL_TURN) : w_yd;
        end
        w_yu = w_y1 + w_step;
        w_y2 = w_y1;
        if (r_keys[1]) begin
            w_y2 = (w_yu >= DEG_HALF_TURN) ? (w_yu - DEG_FULL_TURN) : w_yu;
        end

        // Pitch: down first, then up, each clamped to its limit.
        w_p0 = {{(WORK_W-PITCH_W){r_pitch[PITCH_W-1]}}, r_pitch};
        w_pd = w_p0 - w_step;
        w_p1 = w_p0;
        if (r_keys[2]) begin
            w_p1 = (w_pd <= w_pmin) ? w_pmin : w_pd;
        end
        w_pu = w_p1 + w_step;
        w_p2 = w_p1;
        if (r_keys[3]) begin
            w_p2 = (w_pu >= w_pmax) ? w_pmax : w_pu;
        end

        // Look-at height above the player.
        w_ty_sum = $signed({{(SUM_W-PW){r_py[PW-1]}}, r_py})
                 + $signed({{(SUM_W-LEN_W){1'b0}}, r_height});
    end

    // Sine and cosine of the selected angle
    logic signed [YAW_W-1:0]   w_pclamp, w_tang;
    logic [YAW_W-1:0]          w_abs_full, w_abs;
    logic [SINE_IDX_W-1:0]     w_sidx, w_cidx;
    logic                      w_cneg;
    logic [SINE_W-1:0]         w_sv, w_cv;
    logic signed [TRIG_W-1:0]  w_sin, w_cos;

    always_comb begin
        w_pclamp = {{(YAW_W-PITCH_W){r_pitch[PITCH_W-1]}}, r_pitch};
        if (w_pclamp > DEG_RIGHT) begin
            w_pclamp = DEG_RIGHT;
        end else if (w_pclamp < -DEG_RIGHT) begin
            w_pclamp = -DEG_RIGHT;
        end
        w_tang     = i_cmd.trig_yaw ? r_yaw : w_pclamp;
        w_abs_full = w_tang[YAW_W-1] ? YAW_W'(-w_tang) : YAW_W'(w_tang);
        w_abs      = (w_abs_full > DEG_MAX_ABS) ? DEG_MAX_ABS : w_abs_full;

        if (w_abs <= YAW_W'(DEG_RIGHT)) begin
            w_sidx = w_abs[SINE_IDX_W-1:0];
            w_cidx = SINE_IDX_W'(YAW_W'(DEG_RIGHT) - w_abs);
            w_cneg = 1'b0;
        end else begin
            w_sidx = SINE_IDX_W'(DEG_MAX_ABS - w_abs);
            w_cidx = SINE_IDX_W'(w_abs - YAW_W'(DEG_RIGHT));
            w_cneg = 1'b1;
        end
        w_sv  = f_sine(w_sidx);
        w_cv  = f_sine(w_cidx);
        w_sin = w_tang[YAW_W-1] ? -$signed({1'b0, w_sv}) : $signed({1'b0, w_sv});
        w_cos = w_cneg ? -$signed({1'b0, w_cv}) : $signed({1'b0, w_cv});
    end

    // Shared multiplier
    logic signed [TRIG_W-1:0] w_mul_a;
    logic signed [CPR_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SP_R:   w_mul_a = r_sp;
            MUL_CP_R:   w_mul_a = r_cp;
            MUL_SY_CPR: w_mul_a = r_sy;
            MUL_CY_CPR: w_mul_a = r_cy;
            default:    w_mul_a = r_sp;
        endcase
        if (i_cmd.mul_sel == MUL_SP_R || i_cmd.mul_sel == MUL_CP_R) begin
            w_mul_b = $signed({{(CPR_W-LEN_W){1'b0}}, r_dist});
        end else begin
            w_mul_b = r_cpr;
        end
        w_prod = w_mul_a * w_mul_b;
    end

    // Rounding to nearest, ties away from zero, and the shared offset adder
    logic signed [PROD_W-1:0] w_neg_adj, w_rnd14, w_rnd28, w_off;
    logic signed [PW-1:0]     w_base;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PW-1:0]     w_sum_sat;

    always_comb begin
        w_neg_adj = $signed({{(PROD_W-1){1'b0}}, r_prod[PROD_W-1]});
        w_rnd14   = (r_prod + HALF_14 - w_neg_adj) >>> 14;
        w_rnd28   = (r_prod + HALF_28 - w_neg_adj) >>> 28;
        if (i_cmd.add_y) begin
            w_base = r_ty;
            w_off  = w_rnd14;
        end else if (i_cmd.add_x) begin
            w_base = r_px;
            w_off  = w_rnd28;
        end else begin
            w_base = r_pz;
            w_off  = -w_rnd28;
        end
        w_sum = $signed({{(SUM_W-PW){w_base[PW-1]}}, w_base})
              + $signed({w_off[PROD_W-1], w_off});
        w_sum_sat = f_sat(w_sum);
    end

    // Configuration registers and the stored angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= RST_ANGLE_STEP;
            r_height <= RST_HEIGHT;
            r_dist   <= RST_DISTANCE;
            r_pmin   <= RST_PITCH_MIN;
            r_pmax   <= RST_PITCH_MAX;
            r_yaw    <= RST_YAW;
            r_pitch  <= RST_PITCH;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ANGLE_STEP:     r_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_LOOK_HEIGHT:    r_height <= i_cfg_data[LEN_W-1:0];
                    CFG_ORBIT_DISTANCE: r_dist   <= i_cfg_data[LEN_W-1:0];
                    CFG_PITCH_MIN:      r_pmin   <= i_cfg_data[PITCH_W-1:0];
                    CFG_PITCH_MAX:      r_pmax   <= i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd_angle) begin
                r_yaw   <= w_y2[YAW_W-1:0];
                r_pitch <= w_p2[PITCH_W-1:0];
            end
        end
    end

    // Working registers of the current word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_keys <= i_in_data[KEY_W-1:0];
            r_px   <= i_in_data[KEY_W +: PW];
            r_py   <= i_in_data[KEY_W + PW +: PW];
            r_pz   <= i_in_data[KEY_W + 2 * PW +: PW];
        end
        if (i_cmd.upd_angle) begin
            r_ty <= f_sat(w_ty_sum);
        end
        if (i_cmd.trig_pitch) begin
            r_sp <= w_sin;
            r_cp <= w_cos;
        end
        if (i_cmd.trig_yaw) begin
            r_sy <= w_sin;
            r_cy <= w_cos;
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MUL_CP_R) begin
                r_cpr <= w_prod[CPR_W-1:0];
            end else begin
                r_prod <= w_prod;
            end
        end
        if (i_cmd.add_y) begin
            r_cam_y <= w_sum_sat;
        end
        if (i_cmd.add_x) begin
            r_cam_x <= w_sum_sat;
        end
        if (i_cmd.add_z) begin
            r_cam_z <= w_sum_sat;
        end
        if (i_cmd.out_load) begin
            r_out_data <= OUT_W'({r_pitch, r_yaw, r_pz, r_ty, r_px,
                                  r_cam_z, r_cam_y, r_cam_x});
        end
    end

    assign o_out_data = r_out_data;

endmodule

`default_nettype wire

[rtl/core/orbit_camera_angle_and_position_top.sv]
// Top level of the third-person orbit camera block.
//
// One input word per frame carries four key flags and the player position.
// The block steps its stored yaw and pitch by the held keys, then returns the
// look-at point (player raised by the look height) and the camera position
// placed at the orbit distance by pitch and yaw, with both angles.
// Input and output are stream channels; a word moves when tvalid and tready
// are both high. Registers are written through i_cfg_we, i_cfg_addr and
// i_cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. The sequencer runs one word at a time
// through the angle update, two table look-ups and four passes of one shared
// 16 x 32 multiplier, and takes no new input word until it is back in idle.
// A finished word sits in the output register; the next input word is taken
// while it waits, and the sequencer holds its last step until that register
// is free. Synchronous reset restores the register defaults, zeroes the yaw,
// sets the pitch to minus three degrees, empties the output and holds the
// input not ready.
`default_nettype none

module orbit_camera_angle_and_position_top
    import ocap_pkg::*;
#(
    parameter int  POSITION_WIDTH = POSITION_WIDTH_DEF,
    localparam int IN_FIELD_W     = KEY_W + 3 * POSITION_WIDTH,
    localparam int IN_W           = ((IN_FIELD_W + 7) / 8) * 8,
    localparam int OUT_FIELD_W    = 6 * POSITION_WIDTH + YAW_W + PITCH_W,
    localparam int OUT_W          = ((OUT_FIELD_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // From bit 0: key_yaw_down, key_yaw_up, key_pitch_down, key_pitch_up,
    // player_x, player_y, player_z, zero padding.
    input  wire logic [IN_W-1:0]       s_axis_tdata,
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // From bit 0: camera_x, camera_y, camera_z, target_x, target_y, target_z,
    // yaw_now, pitch_now, zero padding.
    output logic [OUT_W-1:0]           m_axis_tdata
);

    t_dp_cmd w_cmd;

    // Sequencer
    ocap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Datapath
    ocap_dp #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

[tb/tb_camera_pkg.sv]
`timescale 1ns / 1ps
// Pose predictor and result checker for the orbit camera testbench.
package tb_camera_pkg;
    import ocap_pkg::*;

    localparam int PW      = POSITION_WIDTH_DEF;
    localparam int FRAME_W = ((KEY_W + 3 * PW + 7) / 8) * 8;
    localparam int POSE_W  = ((6 * PW + YAW_W + PITCH_W + 7) / 8) * 8;

    // Key flags, one bit each, from bit 0 of the input word.
    localparam logic [KEY_W-1:0] KEY_YAW_DOWN   = 4'b0001;
    localparam logic [KEY_W-1:0] KEY_YAW_UP     = 4'b0010;
    localparam logic [KEY_W-1:0] KEY_PITCH_DOWN = 4'b0100;
    localparam logic [KEY_W-1:0] KEY_PITCH_UP   = 4'b1000;

    // Sine of whole degrees 0..90, scaled by 2^14.
    localparam int SIN_DEG [91] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11983, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct {
        logic signed [PW-1:0]      cam_x;
        logic signed [PW-1:0]      cam_y;
        logic signed [PW-1:0]      cam_z;
        logic signed [PW-1:0]      tgt_x;
        logic signed [PW-1:0]      tgt_y;
        logic signed [PW-1:0]      tgt_z;
        logic signed [YAW_W-1:0]   yaw;
        logic signed [PITCH_W-1:0] pitch;
    } cam_pose_t;

    class camera_pose_checker;
        logic [STEP_W-1:0] angle_step;
        logic [LEN_W-1:0]  look_height;
        logic [LEN_W-1:0]  orbit_distance;
        int                pitch_min;
        int                pitch_max;
        int                yaw_deg;
        int                pitch_deg;
        cam_pose_t         pending_poses[$];
        int                failures;

        function new();
            angle_step     = 6'd3;
            look_height    = 16'd240;
            orbit_distance = 16'd1600;
            pitch_min      = -5;
            pitch_max      = 89;
            yaw_deg        = 0;
            pitch_deg      = -3;
            failures       = 0;
        endfunction

        // Mirror of a register write.
        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ANGLE_STEP:     angle_step = val[STEP_W-1:0];
                CFG_LOOK_HEIGHT:    look_height = val;
                CFG_ORBIT_DISTANCE: orbit_distance = val;
                CFG_PITCH_MIN:      pitch_min = int'($signed(val[PITCH_W-1:0]));
                CFG_PITCH_MAX:      pitch_max = int'($signed(val[PITCH_W-1:0]));
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_poses.size();
        endfunction

        function longint clamp_pos(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (PW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Divide by 2^sh, rounding to nearest with ties away from zero.
        function longint round_away(longint v, int sh);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
            return (v < 0) ? -m : m;
        endfunction

        // Sine and cosine of a whole degree angle in -180..180.
        function void trig_deg(int deg, output longint s, output longint c);
            int a;
            a = (deg < 0) ? -deg : deg;
            if (a > 180) a = 180;
            if (a <= 90) begin
                s = SIN_DEG[a];
                c = SIN_DEG[90 - a];
            end else begin
                s = SIN_DEG[180 - a];
                c = -longint'(SIN_DEG[a - 90]);
            end
            if (deg < 0) s = -s;
        endfunction

        // Step the angles for an accepted frame and queue the pose it yields.
        function void take_frame(logic [KEY_W-1:0] keys, logic signed [PW-1:0] px,
                                 logic signed [PW-1:0] py, logic signed [PW-1:0] pz);
            int        st;
            int        pa;
            longint    r, ty, sp, cp, sy, cy, dx, dy, dz;
            cam_pose_t p;
            st = int'(angle_step);
            if ((keys & KEY_YAW_DOWN) != 0) begin
                yaw_deg -= st;
                if (yaw_deg <= -180) yaw_deg += 360;
            end
            if ((keys & KEY_YAW_UP) != 0) begin
                yaw_deg += st;
                if (yaw_deg >= 180) yaw_deg -= 360;
            end
            if ((keys & KEY_PITCH_DOWN) != 0) begin
                pitch_deg -= st;
                if (pitch_deg <= pitch_min) pitch_deg = pitch_min;
            end
            if ((keys & KEY_PITCH_UP) != 0) begin
                pitch_deg += st;
                if (pitch_deg >= pitch_max) pitch_deg = pitch_max;
            end

            ty = clamp_pos(longint'(px) * 0 + longint'(py) + longint'(look_height));

            // Placement uses the pitch held within a quarter turn.
            pa = pitch_deg;
            if (pa > 90) pa = 90;
            if (pa < -90) pa = -90;
            trig_deg(pa, sp, cp);
            trig_deg(yaw_deg, sy, cy);
            r  = longint'(orbit_distance);
            dy = round_away(sp * r, 14);
            dx = round_away(sy * cp * r, 28);
            dz = -round_away(cy * cp * r, 28);

            p.cam_x = PW'(clamp_pos(longint'(px) + dx));
            p.cam_y = PW'(clamp_pos(ty + dy));
            p.cam_z = PW'(clamp_pos(longint'(pz) + dz));
            p.tgt_x = px;
            p.tgt_y = PW'(ty);
            p.tgt_z = pz;
            p.yaw   = YAW_W'(yaw_deg);
            p.pitch = PITCH_W'(pitch_deg);
            pending_poses.push_back(p);
        endfunction

        function void report(string what);
            if (failures < 10) $display("%s", what);
            failures++;
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got)
                report($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
        endfunction

        // Compare an output word with the oldest queued pose.
        function void check_pose(logic [POSE_W-1:0] d);
            cam_pose_t want;
            cam_pose_t got;
            got.cam_x = d[0 * PW +: PW];
            got.cam_y = d[1 * PW +: PW];
            got.cam_z = d[2 * PW +: PW];
            got.tgt_x = d[3 * PW +: PW];
            got.tgt_y = d[4 * PW +: PW];
            got.tgt_z = d[5 * PW +: PW];
            got.yaw   = d[6 * PW +: YAW_W];
            got.pitch = d[6 * PW + YAW_W +: PITCH_W];
            if (pending_poses.size() == 0) begin
                report("pose word arrived with no frame outstanding");
                return;
            end
            want = pending_poses.pop_front();
            check_field("camera_x", want.cam_x, got.cam_x);
            check_field("camera_y", want.cam_y, got.cam_y);
            check_field("camera_z", want.cam_z, got.cam_z);
            check_field("target_x", want.tgt_x, got.tgt_x);
            check_field("target_y", want.tgt_y, got.tgt_y);
            check_field("target_z", want.tgt_z, got.tgt_z);
            check_field("yaw_now", want.yaw, got.yaw);
            check_field("pitch_now", want.pitch, got.pitch);
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for the orbit camera block: stimulus, stalls and checking.
module tb_top;
    import ocap_pkg::*;
    import tb_camera_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int POS_HI      = (1 << (PW - 1)) - 1;
    localparam int POS_LO      = -(1 << (PW - 1));

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // From bit 0: key_yaw_down, key_yaw_up, key_pitch_down, key_pitch_up,
    // player_x, player_y, player_z, zero padding.
    logic [FRAME_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // From bit 0: camera_x, camera_y, camera_z, target_x, target_y, target_z,
    // yaw_now, pitch_now, zero padding.
    logic [POSE_W-1:0]     m_axis_tdata;

    logic                  idle_on   = 1'b1;
    int unsigned           hold_asks = 0;
    int unsigned           hold_seen = 0;
    int unsigned           hold_left = 0;
    camera_pose_checker    poses;

    orbit_camera_angle_and_position_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: check each accepted word, then pick the next ready level.
    // A hold-off request from the stimulus turns ready off for a long stretch.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            poses.check_pose(m_axis_tdata);
        end
        if (hold_seen != hold_asks) begin
            hold_seen     <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 24);
        end
    end

    // Offer one frame word, with random idle cycles first, and wait for it to go.
    task automatic send_frame(logic [KEY_W-1:0] keys, logic signed [PW-1:0] px,
                              logic signed [PW-1:0] py, logic signed [PW-1:0] pz);
        while (idle_on && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= FRAME_W'({pz, py, px, keys});
        do @(posedge i_clk); while (!s_axis_tready);
        poses.take_frame(keys, px, py, pz);
    endtask

    // Stop offering and wait until every queued pose has come back.
    task automatic wait_for_poses();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (poses.pending() != 0);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        poses.set_reg(idx, val);
    endtask

    // Mostly full-range positions, with some near either rail and some small.
    function automatic logic signed [PW-1:0] any_position();
        case ($urandom_range(0, 7))
            0: return PW'(POS_HI - int'($urandom_range(0, 70000)));
            1: return PW'(POS_LO + int'($urandom_range(0, 70000)));
            2: return PW'(int'($urandom_range(0, 8192)) - 4096);
            default: return PW'($urandom);
        endcase
    endfunction

    // Register settings per phase: the first few are the extremes and the
    // odd cases (no step, crossed limits, limits past a quarter turn).
    task automatic set_registers(int ph);
        logic [STEP_W-1:0]         st;
        logic [LEN_W-1:0]          h;
        logic [LEN_W-1:0]          d;
        logic signed [PITCH_W-1:0] lo;
        logic signed [PITCH_W-1:0] hi;
        case (ph)
            0: begin
                st = 6'd45; h = '1; d = '1; lo = -8'sd90; hi = 8'sd90;
            end
            1: begin
                st = 6'd0; h = '0; d = '0; lo = 8'sd90; hi = -8'sd90;
            end
            2: begin
                st = 6'd63; h = LEN_W'($urandom); d = '1; lo = -8'sd128; hi = 8'sd127;
            end
            3: begin
                st = 6'd1; h = LEN_W'($urandom); d = LEN_W'($urandom); lo = '0; hi = '0;
            end
            4: begin
                st = 6'd7; h = 16'd240; d = 16'd1600; lo = 8'sd30; hi = -8'sd30;
            end
            default: begin
                st = STEP_W'($urandom_range(1, 45));
                h  = LEN_W'($urandom);
                d  = LEN_W'($urandom);
                lo = PITCH_W'(int'($urandom_range(0, 180)) - 90);
                hi = PITCH_W'(int'($urandom_range(0, 180)) - 90);
                if ($urandom_range(0, 3) == 0) lo = PITCH_W'($urandom);
            end
        endcase
        write_reg(CFG_ANGLE_STEP, CFG_DATA_W'(st));
        write_reg(CFG_LOOK_HEIGHT, h);
        write_reg(CFG_ORBIT_DISTANCE, d);
        write_reg(CFG_PITCH_MIN, CFG_DATA_W'(lo));
        write_reg(CFG_PITCH_MAX, CFG_DATA_W'(hi));
    endtask

    initial begin
        poses = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings: rails, each key, all keys.
        send_frame('0, 0, 0, 0);
        send_frame(KEY_YAW_DOWN | KEY_YAW_UP | KEY_PITCH_DOWN | KEY_PITCH_UP,
                   PW'(POS_HI), PW'(POS_HI), PW'(POS_HI));
        send_frame('0, PW'(POS_LO), PW'(POS_LO), PW'(POS_LO));
        send_frame(KEY_YAW_DOWN, 1, -1, 16);
        send_frame(KEY_YAW_UP, -16, PW'(POS_HI - 100), 12345);
        send_frame(KEY_PITCH_DOWN, 777, -4321, -1);
        send_frame(KEY_PITCH_UP, -8, 8, PW'(POS_LO + 5));

        // A large step walks the yaw through both wrap points and the pitch
        // into both limits.
        wait_for_poses();
        write_reg(CFG_ANGLE_STEP, 16'd45);
        repeat (4) send_frame(KEY_YAW_UP, any_position(), any_position(), any_position());
        repeat (8) send_frame(KEY_YAW_DOWN, any_position(), any_position(), any_position());
        repeat (3) send_frame(KEY_PITCH_UP, any_position(), any_position(), any_position());
        repeat (3) send_frame(KEY_PITCH_DOWN, any_position(), any_position(), any_position());

        // Random frames over a series of register settings. Phase 2 starts
        // with a long output hold-off; phase 3 runs with no idling at all.
        for (int ph = 0; ph < 10; ph++) begin
            wait_for_poses();
            set_registers(ph);
            idle_on <= (ph != 3);
            if (ph == 2) hold_asks <= hold_asks + 1;
            repeat (70) begin
                send_frame(KEY_W'($urandom_range(0, 15)),
                           any_position(), any_position(), any_position());
            end
        end

        wait_for_poses();
        repeat (20) @(posedge i_clk);
        if (poses.failures == 0 && poses.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
